@@ sv/framed_packet_seven_segment_mux_top_macros.svh @@
// Assertion macros for the framed packet seven-segment mux.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef FRAMED_PACKET_SEVEN_SEGMENT_MUX_TOP_MACROS_SVH
`define FRAMED_PACKET_SEVEN_SEGMENT_MUX_TOP_MACROS_SVH

// Plain property, checked on every clock edge outside reset
`define FPSSM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle implication, checked outside reset
`define FPSSM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fpssm_pkg.sv @@
// Shared types, constants and helper functions of the framed packet
// seven-segment mux. No dependencies.
package fpssm_pkg;

  localparam int FrameLength = 22;
  localparam int DigitCount  = 5;
  localparam int IndexWidth  = $clog2(FrameLength + 1);
  localparam int CountWidth  = $clog2(DigitCount);

  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharHash    = 8'h23;
  localparam logic [7:0] CharComma   = 8'h2C;
  localparam logic [7:0] CharOne     = 8'h31;
  localparam logic [7:0] SegDash     = 8'h02;

  // Frame character i sits in element [i]
  typedef logic [FrameLength-1:0][7:0] frame_t;

  // Received byte handed to the frame receiver
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } rx_req_t;

  localparam logic [FrameLength*8-1:0] DefaultString = "#00,00,0,000,00,00,00#";

  function automatic frame_t default_frame();
    frame_t f;
    for (int i = 0; i < FrameLength; i++) begin
      f[i] = DefaultString[(FrameLength-1-i)*8 +: 8];
    end
    return f;
  endfunction

  localparam frame_t DefaultFrame = default_frame();

  // Segment pattern of a character, dash for anything but a decimal digit
  function automatic logic [7:0] seg_encode(logic [7:0] ch);
    logic [7:0] pat;
    unique case (ch)
      8'h30:   pat = 8'hFC;
      8'h31:   pat = 8'h60;
      8'h32:   pat = 8'hDA;
      8'h33:   pat = 8'hF2;
      8'h34:   pat = 8'h66;
      8'h35:   pat = 8'hB6;
      8'h36:   pat = 8'hBE;
      8'h37:   pat = 8'hE0;
      8'h38:   pat = 8'hFE;
      8'h39:   pat = 8'hF6;
      default: pat = SegDash;
    endcase
    return pat;
  endfunction

  // Frame position shown on each digit
  function automatic logic [IndexWidth-1:0] digit_pos(logic [CountWidth-1:0] d);
    logic [IndexWidth-1:0] pos;
    unique case (d)
      3'd0:    pos = 5'd1;
      3'd1:    pos = 5'd2;
      3'd2:    pos = 5'd4;
      3'd3:    pos = 5'd5;
      3'd4:    pos = 5'd7;
      default: pos = 5'd0;
    endcase
    return pos;
  endfunction

endpackage

@@ sv/fpssm_if.sv @@
// Valid/ready channel interfaces for the input and result transactions.
// No dependencies.
interface fpssm_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface fpssm_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] digit_select;
  logic [7:0] segment_byte;
  logic [7:0] flag_byte;

  modport source (output valid, digit_select, segment_byte, flag_byte, input ready);
  modport sink   (input valid, digit_select, segment_byte, flag_byte, output ready);
endinterface

@@ sv/fpssm_frame_rx.sv @@
// Frame receiver: collects bytes, checks delimiters, updates display frame.
// Depends on fpssm_pkg.
module fpssm_frame_rx (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpssm_pkg::rx_req_t req_i,
  output fpssm_pkg::frame_t  frame_o
);
  import fpssm_pkg::*;

  frame_t                buf_q, buf_d;
  frame_t                frame_q, frame_d;
  logic [IndexWidth-1:0] idx_q, idx_d;
  frame_t                cand;
  logic                  cand_ok;

  // Candidate frame with the closing byte in place
  always_comb begin
    cand                = buf_q;
    cand[FrameLength-1] = req_i.data;
    cand_ok = (cand[0] == CharHash) && (cand[FrameLength-1] == CharHash) &&
              (cand[3] == CharComma) && (cand[6] == CharComma) &&
              (cand[8] == CharComma) && (cand[12] == CharComma) &&
              (cand[15] == CharComma) && (cand[18] == CharComma);
  end

  // Store byte, advance index, swap in a good frame on completion; a newline restarts the frame
  always_comb begin
    buf_d   = buf_q;
    idx_d   = idx_q;
    frame_d = frame_q;
    if (req_i.valid) begin
      priority if (req_i.data == CharNewline) begin
        idx_d = '0;
      end else if (idx_q >= IndexWidth'(FrameLength)) begin
        idx_d = '0;
      end else begin
        buf_d[idx_q] = req_i.data;
        if (idx_q == IndexWidth'(FrameLength - 1)) begin
          idx_d = '0;
          if (cand_ok) begin
            frame_d = cand;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      frame_q <= DefaultFrame;
    end else begin
      idx_q   <= idx_d;
      frame_q <= frame_d;
    end
  end

  assign frame_o = frame_q;

endmodule

@@ sv/framed_packet_seven_segment_mux_top.sv @@
// Framed packet seven-segment mux: byte transactions feed the frame receiver,
// tick transactions produce one registered digit/segment/flag result.
// A tick's result is registered and valid in the cycle after its transaction.
// Throughput: one transaction per cycle while the single output register is free or drained.
// Reset: index and digit counter clear, display frame takes the default string.
module framed_packet_seven_segment_mux_top (
  input logic         clk_i,
  input logic         rst_ni,
  fpssm_in_if.sink    in_i,
  fpssm_out_if.source out_o
);
  import fpssm_pkg::*;

  `include "framed_packet_seven_segment_mux_top_macros.svh"

  logic                  accept;
  logic                  tick_acc;
  rx_req_t               rx_req;
  frame_t                frame;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic [7:0]            pattern;
  logic [4:0]            select;
  logic [7:0]            flags;
  logic                  out_valid_q;
  logic [4:0]            sel_q;
  logic [7:0]            seg_q;
  logic [7:0]            flag_q;

  // Accept while the result register is free or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign tick_acc   = accept && in_i.command;

  assign rx_req.valid = accept && !in_i.command;
  assign rx_req.data  = in_i.rx_byte;

  fpssm_frame_rx u_frame_rx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (rx_req),
    .frame_o (frame)
  );

  // Pick the digit character, encode segments and flags, and advance the digit counter on a tick
  always_comb begin
    if (cnt_q < CountWidth'(DigitCount)) begin
      pattern = seg_encode(frame[digit_pos(cnt_q)]);
      select  = 5'(5'd1 << cnt_q);
    end else begin
      pattern = SegDash;
      select  = '0;
    end
    flags = {frame[10] == CharOne, frame[11] == CharOne,
             frame[13] == CharOne, frame[14] == CharOne,
             frame[16] == CharOne, frame[17] == CharOne,
             frame[19] == CharOne, frame[20] == CharOne};
    cnt_d = cnt_q;
    if (tick_acc) begin
      cnt_d = (cnt_q >= CountWidth'(DigitCount - 1)) ? '0 : cnt_q + 1'b1;
    end
  end

  // Hold the result until taken and update the digit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (tick_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      sel_q  <= select;
      seg_q  <= {pattern[7:1], frame[9] == CharOne};
      flag_q <= flags;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.digit_select = sel_q;
  assign out_o.segment_byte = seg_q;
  assign out_o.flag_byte    = flag_q;

  `FPSSM_ASSERT(a_cnt_range, cnt_q < CountWidth'(DigitCount), "digit counter out of range")
  `FPSSM_ASSERT(a_sel_onehot, !out_valid_q || $onehot(sel_q), "digit select not one-hot")
  `FPSSM_ASSERT_NEXT(a_tick_result, tick_acc, out_valid_q, "tick left no result")
  `FPSSM_ASSERT_NEXT(a_cnt_advance, tick_acc, cnt_q != $past(cnt_q), "counter did not move")

endmodule
